/* rtl/brb_pkg.sv */
`default_nettype none
package brb_pkg;

   localparam int STORE_DEPTH = 1024;
   localparam int MAX_BLOCK   = 64;
   localparam int PTR_W       = $clog2(STORE_DEPTH);
   localparam int SIZE_W      = 11;
   localparam int LEN_W       = 7;
   localparam int OFF_W       = 12;
   localparam int BYTE_W      = 8;
   localparam int FUNC_W      = 3;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH      = 3'd0,
      FUNC_POP       = 3'd1,
      FUNC_PEEK      = 3'd2,
      FUNC_SKIP      = 3'd3,
      FUNC_SEEK_HEAD = 3'd4,
      FUNC_SEEK_TAIL = 3'd5,
      FUNC_CLEAR     = 3'd6
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_REJECT = 2'd1,
      STATUS_RANGE  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ
   } state_type;

   typedef struct packed {
      logic clr_we;
      logic take;
      logic read_step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic block_read;
      logic count_one;
      logic slot_free;
   } dp_status_type;

endpackage
`default_nettype wire

/* rtl/brb_ctrl.sv */
`default_nettype none
module brb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  brb_pkg::dp_status_type stat,
   output brb_pkg::ctrl_cmd_type  cmd,
   output logic                  req_ready
);
   import brb_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && stat.slot_free && stat.block_read) state_in = ST_READ;
         end
         ST_READ: begin
            if (stat.slot_free && stat.count_one) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_we = 1'b1;
         end
         ST_IDLE: begin
            req_ready = stat.slot_free;
            cmd.take  = req_valid && stat.slot_free;
         end
         ST_READ: begin
            cmd.read_step = stat.slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

/* rtl/brb_datapath.sv */
`default_nettype none
module brb_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  brb_pkg::ctrl_cmd_type               cmd,
   output brb_pkg::dp_status_type              stat,
   input  logic [brb_pkg::FUNC_W-1:0]          req_func,
   input  logic [brb_pkg::BYTE_W-1:0]          req_byte,
   input  logic [brb_pkg::LEN_W-1:0]           req_len,
   input  logic                                req_first,
   input  logic [brb_pkg::OFF_W-1:0]           req_offset,
   input  logic                                csr_we,
   input  logic [brb_pkg::SIZE_W-1:0]          csr_wdata,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [brb_pkg::BYTE_W-1:0]          rsp_byte,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_last,
   output logic [brb_pkg::SIZE_W-1:0]          rsp_used,
   output logic [brb_pkg::SIZE_W-1:0]          rsp_free,
   output logic [brb_pkg::PTR_W-1:0]           rsp_head,
   output logic [brb_pkg::PTR_W-1:0]           rsp_tail
);
   import brb_pkg::*;

   function automatic logic [PTR_W-1:0] step_pos(input logic [PTR_W-1:0] pos,
                                                 input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] n;
      logic [PTR_W-1:0]  r;
      n = SIZE_W'(pos) + SIZE_W'(1);
      if (n >= size) r = '0;
      else r = n[PTR_W-1:0];
      return r;
   endfunction

   function automatic logic [PTR_W-1:0] seek_to(input logic [PTR_W-1:0] pos,
                                                input logic signed [OFF_W:0] off,
                                                input logic signed [OFF_W:0] lim);
      logic signed [OFF_W:0] p;
      p = $signed({{(OFF_W + 1 - PTR_W){1'b0}}, pos}) + off;
      if (p < 0) p = p + lim;
      else if (p >= lim) p = p - lim;
      return p[PTR_W-1:0];
   endfunction

   logic [BYTE_W-1:0]  store_mem [STORE_DEPTH];

   logic [SIZE_W-1:0]  size_ff;
   logic [PTR_W-1:0]   head_ff, tail_ff;
   logic [LEN_W-1:0]   push_left_ff;
   logic               push_acc_ff;
   logic [PTR_W-1:0]   clr_addr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [LEN_W-1:0]   count_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         status_ff;
   logic               last_ff;
   logic               byte_en_ff;
   logic [BYTE_W-1:0]  mem_q_ff;

   logic [SIZE_W-1:0]  ring_size, used, free, skip_sum;
   logic [PTR_W-1:0]   head_skip;
   logic               len_ok, read_ok, block_read, slot_free;
   logic signed [OFF_W:0] off_x, lim_x;
   logic               seek_far;
   logic [LEN_W-1:0]   left_cur;
   logic               acc_cur;
   func_type           func;

   logic [PTR_W-1:0]   head_in, tail_in;
   logic [LEN_W-1:0]   push_left_in;
   logic               push_acc_in;
   logic               push_we;
   status_type         item_status;

   always_comb begin
      if (size_ff == '0) ring_size = SIZE_W'(1);
      else if (size_ff > SIZE_W'(STORE_DEPTH)) ring_size = SIZE_W'(STORE_DEPTH);
      else ring_size = size_ff;
   end

   always_comb begin
      if (tail_ff >= head_ff) used = SIZE_W'(tail_ff) - SIZE_W'(head_ff);
      else used = ring_size + SIZE_W'(tail_ff) - SIZE_W'(head_ff);
   end

   assign free       = ring_size - used;
   assign func       = func_type'(req_func);
   assign len_ok     = (req_len != '0) && (req_len <= LEN_W'(MAX_BLOCK));
   assign read_ok    = len_ok && (SIZE_W'(req_len) <= used);
   assign block_read = ((func == FUNC_POP) || (func == FUNC_PEEK)) && read_ok;
   assign slot_free  = !rsp_valid_ff || rsp_ready;

   assign skip_sum  = SIZE_W'(head_ff) + SIZE_W'(req_len);
   assign head_skip = (skip_sum >= ring_size) ? PTR_W'(skip_sum - ring_size)
                                              : skip_sum[PTR_W-1:0];

   assign off_x    = $signed({req_offset[OFF_W-1], req_offset});
   assign lim_x    = $signed({{(OFF_W + 1 - SIZE_W){1'b0}}, ring_size});
   assign seek_far = (off_x > lim_x) || (off_x < -lim_x);

   assign left_cur = req_first ? req_len : push_left_ff;
   assign acc_cur  = req_first ? (len_ok && (SIZE_W'(req_len) < free)) : push_acc_ff;

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      push_left_in = '0;
      push_acc_in  = 1'b0;
      push_we      = 1'b0;
      item_status  = STATUS_OK;
      case (func)
         FUNC_PUSH: begin
            push_left_in = left_cur;
            push_acc_in  = acc_cur;
            if (left_cur == '0) begin
               item_status = STATUS_REJECT;
            end else begin
               push_left_in = left_cur - LEN_W'(1);
               if (acc_cur) begin
                  push_we = 1'b1;
                  tail_in = step_pos(tail_ff, ring_size);
               end else begin
                  item_status = STATUS_REJECT;
               end
               if (push_left_in == '0) push_acc_in = 1'b0;
            end
         end
         FUNC_POP, FUNC_PEEK, FUNC_SKIP: begin
            if (!read_ok) item_status = STATUS_REJECT;
            else if (func != FUNC_PEEK) head_in = head_skip;
         end
         FUNC_SEEK_HEAD: begin
            if (seek_far) item_status = STATUS_RANGE;
            else head_in = seek_to(head_ff, off_x, lim_x);
         end
         FUNC_SEEK_TAIL: begin
            if (seek_far) item_status = STATUS_RANGE;
            else tail_in = seek_to(tail_ff, off_x, lim_x);
         end
         FUNC_CLEAR: begin
            head_in = '0;
            tail_in = '0;
         end
         default: begin
            item_status = STATUS_REJECT;
         end
      endcase
   end

   // ring state
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= SIZE_W'(STORE_DEPTH);
         head_ff      <= '0;
         tail_ff      <= '0;
         push_left_ff <= '0;
         push_acc_ff  <= 1'b0;
      end else if (csr_we) begin
         size_ff      <= csr_wdata;
         head_ff      <= '0;
         tail_ff      <= '0;
         push_left_ff <= '0;
         push_acc_ff  <= 1'b0;
      end else if (cmd.take) begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         push_left_ff <= push_left_in;
         push_acc_ff  <= push_acc_in;
      end
   end

   // clearing sweep and block read counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         count_ff    <= '0;
      end else begin
         if (cmd.clr_we) clr_addr_ff <= clr_addr_ff + PTR_W'(1);
         if (cmd.take) count_ff <= req_len;
         else if (cmd.read_step) count_ff <= count_ff - LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) rd_ptr_ff <= head_ff;
      else if (cmd.read_step) rd_ptr_ff <= step_pos(rd_ptr_ff, ring_size);
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_we) store_mem[clr_addr_ff] <= '0;
      else if (cmd.take && push_we && !csr_we) store_mem[tail_ff] <= req_byte;
   end

   always_ff @(posedge clock) begin
      if (cmd.read_step) mem_q_ff <= store_mem[rd_ptr_ff];
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if ((cmd.take && !block_read) || cmd.read_step) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.take && !block_read) begin
         status_ff  <= item_status;
         last_ff    <= 1'b1;
         byte_en_ff <= 1'b0;
      end else if (cmd.read_step) begin
         status_ff  <= STATUS_OK;
         last_ff    <= (count_ff == LEN_W'(1));
         byte_en_ff <= 1'b1;
      end
   end

   assign stat.clr_last   = (clr_addr_ff == PTR_W'(STORE_DEPTH - 1));
   assign stat.block_read = block_read;
   assign stat.count_one  = (count_ff == LEN_W'(1));
   assign stat.slot_free  = slot_free;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_byte   = byte_en_ff ? mem_q_ff : '0;
   assign rsp_status = status_ff;
   assign rsp_last   = last_ff;
   assign rsp_used   = used;
   assign rsp_free   = free;
   assign rsp_head   = head_ff;
   assign rsp_tail   = tail_ff;

endmodule
`default_nettype wire

/* rtl/byte_ring_buffer_block_ops.sv */
`default_nettype none
// Byte ring buffer with block push, pop, peek, skip, head/tail seek and clear.
// After reset the block sweeps its 1024-byte store to zero, one byte a cycle,
// so req_tready stays low until the sweep ends (csr writes are taken meanwhile).
// An item that gives one result (push byte, skip, seek, clear, any reject) is
// taken at its accept, so pushes stream at one byte per cycle while results are
// drained. A pop or peek of L bytes is accepted and then gives L results,
// one byte per cycle out of the single read port of the store; the result
// register stalls both sides when rsp_tready is low. Used, free, head and tail
// in every result show the ring after the whole item.
module byte_ring_buffer_block_ops (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // data_byte[7:0], block_length[14:8], first_of_block[15], seek_offset[27:16], pad
   input  logic [31:0] req_tdata,
   // func[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_byte[7:0], status[9:8], used_count[20:10], free_count[31:21],
   // head_index[41:32], tail_index[51:42], pad
   output logic [55:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [10:0] csr_wdata
);
   import brb_pkg::*;

   ctrl_cmd_type      cmd;
   dp_status_type     stat;
   logic [BYTE_W-1:0] rsp_byte;
   logic [1:0]        rsp_status;
   logic [SIZE_W-1:0] rsp_used, rsp_free;
   logic [PTR_W-1:0]  rsp_head, rsp_tail;

   brb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .stat      (stat),
      .cmd       (cmd),
      .req_ready (req_tready)
   );

   brb_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_func   (req_tuser),
      .req_byte   (req_tdata[7:0]),
      .req_len    (req_tdata[14:8]),
      .req_first  (req_tdata[15]),
      .req_offset (req_tdata[27:16]),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_byte   (rsp_byte),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_tlast),
      .rsp_used   (rsp_used),
      .rsp_free   (rsp_free),
      .rsp_head   (rsp_head),
      .rsp_tail   (rsp_tail)
   );

   assign rsp_tdata = {4'b0, rsp_tail, rsp_head, rsp_free, rsp_used, rsp_status, rsp_byte};

endmodule
`default_nettype wire

/* rtl/brb_checker.sv */
`default_nettype none
module brb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tlast
);
   import brb_pkg::*;

   // store sweep holds off items right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !req_tready)
      else $error("item taken during store clearing");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result changed");

   a_used_free: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (({1'b0, rsp_tdata[20:10]} + {1'b0, rsp_tdata[31:21]})
                      <= 12'(STORE_DEPTH)))
      else $error("used plus free exceeds ring size");

   a_mid_block_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_tdata[9:8] == STATUS_OK))
      else $error("non-final result without ok status");

   a_reject_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[9:8] != STATUS_OK)) |-> (rsp_tlast && (rsp_tdata[7:0] == 8'd0)))
      else $error("rejected item gave data or several results");

endmodule

bind byte_ring_buffer_block_ops brb_checker u_brb_checker (.*);
`default_nettype wire
